>>> design/frustum_plane_extract_cull_unit_defines.svh
// Assertion macros for the block that checks its own control logic.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef FRUSTUM_PLANE_EXTRACT_CULL_UNIT_DEFINES_SVH
`define FRUSTUM_PLANE_EXTRACT_CULL_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPEC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPEC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/fpec_pkg.sv
package fpec_pkg;

   // Operand width of the shared multiplier: 32-bit signed values and 32-bit
   // unsigned magnitudes both fit as 33-bit signed operands.
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = PROD_W + 2;

   localparam int QUEUE_DEPTH = 2;
   localparam int NUM_PLANES  = 6;

   localparam logic [1:0] CMD_VIEW  = 2'd0;
   localparam logic [1:0] CMD_PROJ  = 2'd1;
   localparam logic [1:0] CMD_BUILD = 2'd2;
   localparam logic [1:0] CMD_TEST  = 2'd3;

   typedef enum logic [3:0] {
      OP_VIEW  = 4'b0001,
      OP_PROJ  = 4'b0010,
      OP_BUILD = 4'b0100,
      OP_TEST  = 4'b1000
   } op_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [3:0]         elem_index;
      logic signed [31:0] elem_value;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic [30:0]        box_size;
      logic [30:0]        box_height;
   } req_type;

   typedef struct packed {
      logic       visible;
      logic [1:0] done_cmd;
   } rsp_type;

   typedef struct packed {
      op_type  op;
      req_type req;
   } job_type;

   // Planes in order right, left, bottom, top, far, near.
   localparam logic [1:0] PLANE_COL [NUM_PLANES] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
   localparam logic       PLANE_NEG [NUM_PLANES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

   localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SAT_LO) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> design/frustum_plane_extract_cull_unit.sv
// Channel   Direction   Handshake            Payload
// req       in          req_valid/req_stall  fpec_pkg::req_type (cmd, element, box)
// rsp       out         rsp_valid/rsp_stall  fpec_pkg::rsp_type (visible, done_cmd)
//
// A matrix element write passes from queue head through the done state to the result register.
// A box test runs two 32-step square roots plus 22 multiplies through the one
// shared multiplier. A plane rebuild runs the matrix product, then per plane up
// to four divisions of 32+FRAC_BITS steps each.
// Synchronous reset clears the matrix and plane stores; a 2-deep queue keeps req
// taking transfers until it is full while the back end works or rsp is stalled.
`include "frustum_plane_extract_cull_unit_defines.svh"

module frustum_plane_extract_cull_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fpec_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fpec_pkg::rsp_type rsp_data
);

   // Front end to back end: one classified job at the queue head.
   logic              job_valid;
   logic              job_pop;
   fpec_pkg::job_type job;

   // Back end to result register.
   logic              res_valid;
   logic              res_free;
   fpec_pkg::rsp_type res;

   logic              rsp_valid_ff;
   fpec_pkg::rsp_type rsp_data_ff;

   // The front end takes request transfers and decodes the command into a job.
   fpec_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .out_valid (job_valid),
      .out_job   (job),
      .pop       (job_pop)
   );

   // The back end owns the stores, the shared multiplier, the square root
   // unit and the divider, and runs one job at a time.
   fpec_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop),
      .res_free  (res_free),
      .res_valid (res_valid),
      .res       (res)
   );

   // The result register frees itself in the same cycle its transfer completes,
   // so a finished job can move in without a bubble.
   assign res_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= res;
      end
   end

   // The back end only pops a job that the queue actually holds.
   `FPEC_ASSERT_SAME(a_pop_has_job, job_pop, job_valid, "job popped from an empty queue")
   // A finished result never overwrites one that is still waiting.
   `FPEC_ASSERT_SAME(a_res_slot_free, res_valid, (!rsp_valid_ff || !rsp_stall), "result overwritten")
   // A request transfer always leaves a job in the queue.
   `FPEC_ASSERT_NEXT(a_req_queued, (req_valid && !req_stall), job_valid, "request not queued")

endmodule

>>> design/fpec_front.sv
module fpec_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  fpec_pkg::req_type in_data,
   output logic              out_valid,
   output fpec_pkg::job_type out_job,
   input  logic              pop
);
   localparam int DEPTH = fpec_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   fpec_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   fpec_pkg::op_type  op;
   logic              push;

   // Decode the command once on entry so the back end dispatches on one-hot codes.
   always_comb begin
      unique case (in_data.cmd)
         fpec_pkg::CMD_VIEW:  op = fpec_pkg::OP_VIEW;
         fpec_pkg::CMD_PROJ:  op = fpec_pkg::OP_PROJ;
         fpec_pkg::CMD_BUILD: op = fpec_pkg::OP_BUILD;
         fpec_pkg::CMD_TEST:  op = fpec_pkg::OP_TEST;
         default:             op = fpec_pkg::OP_TEST;
      endcase
   end

   assign in_stall  = (count_ff == CNT_W'(DEPTH));
   assign push      = in_valid && !in_stall;
   assign out_valid = (count_ff != '0);
   assign out_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{op: op, req: in_data};
      end
   end

endmodule

>>> design/fpec_sqrt.sv
module fpec_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [63:0] rad_ff;
   logic [33:0] rem_ff;
   logic [31:0] root_ff;
   logic [35:0] trial;

   // One result bit per cycle, two radicand bits consumed per step.
   assign trial = {rem_ff, rad_ff[63:62]} - {2'b00, root_ff, 2'b01};
   assign done  = done_ff;
   assign root  = root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff <= {rad_ff[61:0], 2'b00};
         if (!trial[35]) begin
            rem_ff  <= trial[33:0];
            root_ff <= {root_ff[30:0], 1'b1};
         end else begin
            rem_ff  <= {rem_ff[31:0], rad_ff[63:62]};
            root_ff <= {root_ff[30:0], 1'b0};
         end
      end
   end

endmodule

>>> design/fpec_div.sv
module fpec_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic [31:0]        den,
   output logic               done,
   output logic signed [31:0] quot
);
   localparam int NUM_W = 32 + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W);

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [NUM_W-1:0]   shift_ff;
   logic [NUM_W-1:0]   q_ff;
   logic [31:0]        rem_ff;
   logic [31:0]        den_ff;
   logic               neg_ff;
   logic [31:0]        mag;
   logic [32:0]        t;
   logic [32:0]        t_sub;
   logic               ge;

   assign mag   = num[31] ? (~num + 32'd1) : num;
   assign t     = {rem_ff, shift_ff[NUM_W-1]};
   assign t_sub = t - {1'b0, den_ff};
   assign ge    = (t >= {1'b0, den_ff});
   assign done  = done_ff;

   // Magnitude quotient saturated to the signed 32-bit range.
   always_comb begin
      if (neg_ff) begin
         if (q_ff > NUM_W'(33'h0_8000_0000)) begin
            quot = 32'sh8000_0000;
         end else begin
            quot = -$signed(q_ff[31:0]);
         end
      end else begin
         if (|q_ff[NUM_W-1:31]) begin
            quot = 32'sh7FFF_FFFF;
         end else begin
            quot = $signed(q_ff[31:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         shift_ff <= NUM_W'(mag) << FRAC_BITS;
         q_ff     <= '0;
         rem_ff   <= '0;
         den_ff   <= den;
         neg_ff   <= num[31];
      end else if (busy_ff) begin
         shift_ff <= {shift_ff[NUM_W-2:0], 1'b0};
         q_ff     <= {q_ff[NUM_W-2:0], ge};
         rem_ff   <= ge ? t_sub[31:0] : t[31:0];
      end
   end

endmodule

>>> design/fpec_back.sv
module fpec_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  fpec_pkg::job_type job,
   output logic              job_pop,
   input  logic              res_free,
   output logic              res_valid,
   output fpec_pkg::rsp_type res
);
   localparam int MW = fpec_pkg::MUL_W;
   localparam int PW = fpec_pkg::PROD_W;
   localparam int AW = fpec_pkg::ACC_W;

   typedef enum logic [9:0] {
      ST_IDLE = 10'h001,
      ST_CLIP = 10'h002,
      ST_RAW  = 10'h004,
      ST_SQ   = 10'h008,
      ST_LEN  = 10'h010,
      ST_DIV  = 10'h020,
      ST_SPH  = 10'h040,
      ST_ROOT = 10'h080,
      ST_DIST = 10'h100,
      ST_DONE = 10'h200
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] ph_ff, ph_in;
   logic [1:0] k_ff, k_in;
   logic [3:0] rc_ff, rc_in;
   logic [2:0] p_ff, p_in;
   logic       pass_ff, pass_in;

   logic signed [31:0] view_ff  [16];
   logic signed [31:0] proj_ff  [16];
   logic signed [31:0] plane_ff [24];
   logic signed [31:0] clip_ff  [16];
   logic signed [31:0] co_ff    [4];

   fpec_pkg::req_type  job_ff;
   logic signed [31:0] ym_ff;
   logic               vis_ff;
   logic signed [31:0] tmp_ff;
   logic [31:0]        len_ff;
   logic [31:0]        edge_ff;
   logic [30:0]        rad_ff;
   logic [63:0]        sq_ff;
   logic signed [MW-1:0] op_a_ff, op_b_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [AW-1:0] acc_ff;

   logic signed [31:0] view_rd, proj_rd, plane_rd, clip_rd, co_rd;
   logic [3:0]         clip_addr;
   logic [29:0]        hs;
   logic signed [MW-1:0] mul_a, mul_b;
   logic               load_ops;
   logic               mac_step;
   logic signed [PW-1:0] prod_sh;
   logic signed [AW-1:0] acc_base, acc_sum, raw_sum;
   logic [63:0]        sq_base;
   logic signed [31:0] dist_sat;
   logic signed [32:0] neg_rad;
   logic               culled;
   logic               plane_wr;
   logic signed [31:0] plane_wd;

   logic               sqrt_start, sqrt_done;
   logic [31:0]        sqrt_root;
   logic               div_start, div_done;
   logic signed [31:0] div_quot;

   fpec_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sq_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   fpec_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (co_rd),
      .den   (len_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Single read port on each store.
   assign view_rd   = view_ff[{rc_ff[3:2], k_ff}];
   assign proj_rd   = proj_ff[{k_ff, rc_ff[1:0]}];
   assign plane_rd  = plane_ff[{p_ff, k_ff}];
   assign clip_addr = (ph_ff == 2'd0) ? {k_ff, 2'd3} : {k_ff, fpec_pkg::PLANE_COL[p_ff]};
   assign clip_rd   = clip_ff[clip_addr];
   assign co_rd     = co_ff[k_ff];
   assign hs        = job_ff.box_size[30:1];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_CLIP) begin
         mul_a = MW'(view_rd);
         mul_b = MW'(proj_rd);
      end else if (state_ff == ST_SQ) begin
         mul_a = MW'(co_rd);
         mul_b = MW'(co_rd);
      end else if (state_ff == ST_SPH) begin
         if (!pass_ff) begin
            mul_a = (k_ff == 2'd0) ? MW'(hs) : MW'(job_ff.box_height);
         end else begin
            mul_a = (k_ff == 2'd0) ? MW'(edge_ff) : MW'(hs);
         end
         mul_b = mul_a;
      end else if (state_ff == ST_DIST) begin
         mul_a = MW'(plane_rd);
         if (k_ff == 2'd0) begin
            mul_b = MW'(job_ff.center_x);
         end else if (k_ff == 2'd1) begin
            mul_b = MW'(ym_ff);
         end else begin
            mul_b = MW'(job_ff.center_z);
         end
      end
   end

   // A multiply takes three phases: load operands, multiply, consume product.
   assign load_ops = (ph_ff == 2'd0) &&
                     ((state_ff == ST_CLIP) || (state_ff == ST_SQ) || (state_ff == ST_SPH) ||
                      ((state_ff == ST_DIST) && (k_ff != 2'd3)));
   assign mac_step = (ph_ff == 2'd2);

   assign prod_sh  = prod_ff >>> FRAC_BITS;
   assign acc_base = (k_ff == 2'd0) ? '0 : acc_ff;
   assign acc_sum  = acc_base + AW'(prod_sh);
   assign sq_base  = (k_ff == 2'd0) ? '0 : sq_ff;
   assign raw_sum  = fpec_pkg::PLANE_NEG[p_ff] ? (AW'(tmp_ff) - AW'(clip_rd))
                                               : (AW'(tmp_ff) + AW'(clip_rd));
   assign dist_sat = fpec_pkg::sat32(acc_ff + AW'(plane_rd));
   assign neg_rad  = -$signed({2'b00, rad_ff});
   assign culled   = ($signed({dist_sat[31], dist_sat}) <= neg_rad);

   assign plane_wr = (state_ff == ST_DIV) &&
                     (((ph_ff == 2'd0) && (len_ff == '0)) || ((ph_ff == 2'd1) && div_done));
   assign plane_wd = (len_ff == '0) ? '0 : div_quot;

   assign res.visible  = vis_ff;
   assign res.done_cmd = job_ff.cmd;

   always_comb begin
      state_in   = state_ff;
      ph_in      = ph_ff;
      k_in       = k_ff;
      rc_in      = rc_ff;
      p_in       = p_ff;
      pass_in    = pass_ff;
      job_pop    = 1'b0;
      res_valid  = 1'b0;
      sqrt_start = 1'b0;
      div_start  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               ph_in   = '0;
               k_in    = '0;
               rc_in   = '0;
               p_in    = '0;
               pass_in = 1'b0;
               unique case (job.op)
                  fpec_pkg::OP_BUILD: state_in = ST_CLIP;
                  fpec_pkg::OP_TEST:  state_in = ST_SPH;
                  default:            state_in = ST_DONE;
               endcase
            end
         end
         ST_CLIP: begin
            if (mac_step) begin
               ph_in = '0;
               k_in  = k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  rc_in = rc_ff + 4'd1;
                  if (rc_ff == 4'd15) begin
                     state_in = ST_RAW;
                  end
               end
            end else begin
               ph_in = ph_ff + 2'd1;
            end
         end
         ST_RAW: begin
            if (ph_ff == 2'd0) begin
               ph_in = 2'd1;
            end else begin
               ph_in = '0;
               k_in  = k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  state_in = ST_SQ;
               end
            end
         end
         ST_SQ: begin
            if (mac_step) begin
               ph_in = '0;
               if (k_ff == 2'd2) begin
                  k_in     = '0;
                  state_in = ST_LEN;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end else begin
               ph_in = ph_ff + 2'd1;
            end
         end
         ST_LEN: begin
            if (ph_ff == 2'd0) begin
               sqrt_start = 1'b1;
               ph_in      = 2'd1;
            end else if (sqrt_done) begin
               ph_in    = '0;
               k_in     = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if ((ph_ff == 2'd0) && (len_ff != '0)) begin
               div_start = 1'b1;
               ph_in     = 2'd1;
            end
            if (plane_wr) begin
               ph_in = '0;
               k_in  = k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  p_in = p_ff + 3'd1;
                  if (p_ff == 3'(fpec_pkg::NUM_PLANES - 1)) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_RAW;
                  end
               end
            end
         end
         ST_SPH: begin
            if (mac_step) begin
               ph_in = '0;
               if (k_ff == 2'd1) begin
                  k_in     = '0;
                  state_in = ST_ROOT;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end else begin
               ph_in = ph_ff + 2'd1;
            end
         end
         ST_ROOT: begin
            if (ph_ff == 2'd0) begin
               sqrt_start = 1'b1;
               ph_in      = 2'd1;
            end else if (sqrt_done) begin
               ph_in = '0;
               k_in  = '0;
               if (!pass_ff) begin
                  pass_in  = 1'b1;
                  state_in = ST_SPH;
               end else begin
                  p_in     = '0;
                  state_in = ST_DIST;
               end
            end
         end
         ST_DIST: begin
            if (k_ff == 2'd3) begin
               ph_in = '0;
               k_in  = '0;
               p_in  = p_ff + 3'd1;
               if (p_ff == 3'(fpec_pkg::NUM_PLANES - 1)) begin
                  state_in = ST_DONE;
               end
            end else if (mac_step) begin
               ph_in = '0;
               k_in  = k_ff + 2'd1;
            end else begin
               ph_in = ph_ff + 2'd1;
            end
         end
         ST_DONE: begin
            if (res_free) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ph_ff    <= '0;
         k_ff     <= '0;
         rc_ff    <= '0;
         p_ff     <= '0;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         k_ff     <= k_in;
         rc_ff    <= rc_in;
         p_ff     <= p_in;
         pass_ff  <= pass_in;
      end
   end

   // Matrix and plane stores are architectural state and clear on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            view_ff[i] <= '0;
            proj_ff[i] <= '0;
         end
         for (int i = 0; i < 24; i++) begin
            plane_ff[i] <= '0;
         end
      end else begin
         if (job_pop && (job.op == fpec_pkg::OP_VIEW)) begin
            view_ff[job.req.elem_index] <= job.req.elem_value;
         end
         if (job_pop && (job.op == fpec_pkg::OP_PROJ)) begin
            proj_ff[job.req.elem_index] <= job.req.elem_value;
         end
         if (plane_wr) begin
            plane_ff[{p_ff, k_ff}] <= plane_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a_ff * op_b_ff;
      if (load_ops) begin
         op_a_ff <= mul_a;
         op_b_ff <= mul_b;
      end
      if (job_pop) begin
         job_ff <= job.req;
         ym_ff  <= fpec_pkg::sat32(AW'(job.req.center_y) + AW'(job.req.box_height[30:1]));
         vis_ff <= (job.op == fpec_pkg::OP_TEST);
      end
      if ((state_ff == ST_CLIP) && mac_step) begin
         acc_ff <= acc_sum;
         if (k_ff == 2'd3) begin
            clip_ff[rc_ff] <= fpec_pkg::sat32(acc_sum);
         end
      end
      if ((state_ff == ST_DIST) && mac_step && (k_ff != 2'd3)) begin
         acc_ff <= acc_sum;
      end
      if ((state_ff == ST_DIST) && (k_ff == 2'd3) && culled) begin
         vis_ff <= 1'b0;
      end
      if (state_ff == ST_RAW) begin
         if (ph_ff == 2'd0) begin
            tmp_ff <= clip_rd;
         end else begin
            co_ff[k_ff] <= fpec_pkg::sat32(raw_sum);
         end
      end
      if (((state_ff == ST_SQ) || (state_ff == ST_SPH)) && mac_step) begin
         sq_ff <= sq_base + prod_ff[63:0];
      end
      if ((state_ff == ST_LEN) && sqrt_done) begin
         len_ff <= sqrt_root;
      end
      if ((state_ff == ST_ROOT) && sqrt_done) begin
         if (!pass_ff) begin
            edge_ff <= sqrt_root;
         end else begin
            rad_ff <= sqrt_root[31] ? '1 : sqrt_root[30:0];
         end
      end
   end

endmodule
